>>> rtl/core/telnet_utf8_ansi_char_decoder_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the telnet character decoder
// Checks are compiled for simulation and become empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef TELNET_UTF8_ANSI_CHAR_DECODER_TOP_DEFINES_SVH
`define TELNET_UTF8_ANSI_CHAR_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// implication check on clk, off while rst_n is low
`define TUACD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tuacd: implication check failed");
// next-cycle check on clk, off while rst_n is low
`define TUACD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tuacd: next-cycle check failed");
`else
`define TUACD_ASSERT_IMPL(lbl, ante, cons)
`define TUACD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/tuacd_pkg.sv
// ---------------------------------------------------------------------------
// tuacd_pkg
// Types, codes and lookup functions of the telnet character decoder.
// ---------------------------------------------------------------------------
package tuacd_pkg;

  localparam int RUNE_W = 42;

  // telnet command bytes
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_DONT = 8'd254;

  // display control bytes
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'o033;
  localparam logic [6:0] CH_SPACE = 7'd32;

  localparam logic [3:0] CNT_MAX    = 4'd15;
  localparam logic [3:0] RED_LEN    = 4'd5;
  localparam logic [3:0] DEF_LEN    = 4'd8;

  // link phase, one-hot
  typedef enum logic [2:0] {
    PH_DATA = 3'b001,
    PH_CMD  = 3'b010,
    PH_OPT  = 3'b100
  } tuacd_phase_t;

  // request held in the input stage
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } tuacd_item_t;

  // decode result toward the output stage
  typedef struct packed {
    logic       emit;
    logic [6:0] char_code;
    logic       red_ink;
  } tuacd_res_t;

  // number of leading one bits of a byte
  function automatic logic [3:0] top_ones(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  // payload bits of a lead byte
  function automatic logic [6:0] lead_bits(input logic [7:0] b, input logic [3:0] n);
    logic [6:0] m;
    m = 7'd0;
    case (n)
      4'd2:    m = 7'h1F;
      4'd3:    m = 7'h0F;
      4'd4:    m = 7'h07;
      4'd5:    m = 7'h03;
      4'd6:    m = 7'h01;
      default: m = 7'h00;
    endcase
    return b[6:0] & m;
  endfunction

  // ESC [ 3 1 m
  function automatic logic [7:0] seq_red_at(input logic [3:0] p);
    logic [7:0] v;
    unique case (p)
      4'd0:    v = CH_ESC;
      4'd1:    v = 8'h5B;
      4'd2:    v = 8'h33;
      4'd3:    v = 8'h31;
      4'd4:    v = 8'h6D;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // ESC [ 3 9 ; 4 9 m
  function automatic logic [7:0] seq_def_at(input logic [3:0] p);
    logic [7:0] v;
    unique case (p)
      4'd0:    v = CH_ESC;
      4'd1:    v = 8'h5B;
      4'd2:    v = 8'h33;
      4'd3:    v = 8'h39;
      4'd4:    v = 8'h3B;
      4'd5:    v = 8'h34;
      4'd6:    v = 8'h39;
      4'd7:    v = 8'h6D;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // rune to typewriter code
  function automatic logic [6:0] rune_to_code(input logic [RUNE_W-1:0] r);
    logic [6:0] c;
    if (r == RUNE_W'('h00B7))      c = 7'o020;
    else if (r == RUNE_W'('h203E)) c = 7'o021;
    else if (r == RUNE_W'('h2192)) c = 7'o022;
    else if (r == RUNE_W'('h2283)) c = 7'o023;
    else if (r == RUNE_W'('h2228)) c = 7'o024;
    else if (r == RUNE_W'('h2227)) c = 7'o025;
    else if (r == RUNE_W'('h2191)) c = 7'o026;
    else if (r == RUNE_W'('h00D7)) c = 7'o027;
    else if (|r[RUNE_W-1:7])       c = CH_SPACE;
    else                           c = r[6:0];
    return c;
  endfunction

endpackage

>>> rtl/core/tuacd_if.sv
// ---------------------------------------------------------------------------
// tuacd_if
// Valid/ready channels of the telnet character decoder.
// ---------------------------------------------------------------------------
interface tuacd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tuacd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       red_ink;

  modport source (output valid, output char_code, output red_ink, input ready);
  modport sink   (input valid, input char_code, input red_ink, output ready);
endinterface

>>> rtl/core/tuacd_in_stage.sv
// ---------------------------------------------------------------------------
// tuacd_in_stage
// Input register: holds one received byte until the decode stage moves on.
// ---------------------------------------------------------------------------
module tuacd_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  tuacd_in_if.sink             in_chan,
  input  logic                 adv,
  output tuacd_pkg::tuacd_item_t item
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       take;

  // free when empty or when the held byte is consumed this cycle
  assign in_chan.ready = !vld_r || adv;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_chan.rx_byte;
    end
  end

  assign item.vld     = vld_r;
  assign item.rx_byte = byte_r;

endmodule

>>> rtl/core/tuacd_decode.sv
// ---------------------------------------------------------------------------
// tuacd_decode
// Telnet, escape and UTF-8 state with the single-pass byte decode.
// ---------------------------------------------------------------------------
module tuacd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tuacd_pkg::tuacd_item_t item,
  input  logic                  fire,
  output tuacd_pkg::tuacd_res_t  res
);

  tuacd_pkg::tuacd_phase_t phase_r, phase_nxt;
  logic                            esc_act_r, esc_act_nxt;
  logic [3:0]                      esc_len_r, esc_len_nxt;
  logic                            may_red_r, may_red_nxt;
  logic                            may_def_r, may_def_nxt;
  logic                            red_r, red_nxt;
  logic [3:0]                      utf_exp_r, utf_exp_nxt;
  logic [3:0]                      utf_cnt_r, utf_cnt_nxt;
  logic [tuacd_pkg::RUNE_W-1:0]    rune_r, rune_nxt;

  logic [7:0] c;
  logic       is_data;
  logic [3:0] nc;
  logic [3:0] esc_len_inc;
  logic [3:0] utf_cnt_inc;
  logic       red_hit;
  logic       def_hit;
  logic       emit;
  logic [6:0] code;

  assign c           = item.rx_byte;
  assign nc          = tuacd_pkg::top_ones(c);
  assign esc_len_inc = (esc_len_r == tuacd_pkg::CNT_MAX) ? esc_len_r : esc_len_r + 4'd1;
  assign utf_cnt_inc = (utf_cnt_r == tuacd_pkg::CNT_MAX) ? utf_cnt_r : utf_cnt_r + 4'd1;
  assign red_hit     = may_red_r && (esc_len_r < tuacd_pkg::RED_LEN) &&
                       (tuacd_pkg::seq_red_at(esc_len_r) == c);
  assign def_hit     = may_def_r && (esc_len_r < tuacd_pkg::DEF_LEN) &&
                       (tuacd_pkg::seq_def_at(esc_len_r) == c);

  // telnet link phase; an IAC after IAC is data
  always_comb begin
    phase_nxt = tuacd_pkg::PH_DATA;
    is_data   = 1'b0;
    unique case (phase_r)
      tuacd_pkg::PH_CMD: begin
        if (c >= tuacd_pkg::TN_WILL && c <= tuacd_pkg::TN_DONT) begin
          phase_nxt = tuacd_pkg::PH_OPT;
        end
        is_data = (c == tuacd_pkg::TN_IAC);
      end
      tuacd_pkg::PH_OPT: begin
        phase_nxt = tuacd_pkg::PH_DATA;
      end
      default: begin
        if (c == tuacd_pkg::TN_IAC) begin
          phase_nxt = tuacd_pkg::PH_CMD;
        end else begin
          is_data = 1'b1;
        end
      end
    endcase
  end

  // display filter: CR drop, escape collect, UTF-8 assembly
  always_comb begin
    esc_act_nxt = esc_act_r;
    esc_len_nxt = esc_len_r;
    may_red_nxt = may_red_r;
    may_def_nxt = may_def_r;
    red_nxt     = red_r;
    utf_exp_nxt = utf_exp_r;
    utf_cnt_nxt = utf_cnt_r;
    rune_nxt    = rune_r;
    emit        = 1'b0;
    code        = c[6:0];
    if (!is_data || c == tuacd_pkg::CH_CR) begin
      // nothing reaches the display
    end else if (c == tuacd_pkg::CH_ESC) begin
      esc_act_nxt = 1'b1;
      esc_len_nxt = 4'd1;
      may_red_nxt = 1'b1;
      may_def_nxt = 1'b1;
    end else if (esc_act_r) begin
      may_red_nxt = red_hit;
      may_def_nxt = def_hit;
      esc_len_nxt = esc_len_inc;
      if (red_hit && esc_len_inc == tuacd_pkg::RED_LEN) begin
        red_nxt     = 1'b1;
        esc_act_nxt = 1'b0;
      end else if (def_hit && esc_len_inc == tuacd_pkg::DEF_LEN) begin
        red_nxt     = 1'b0;
        esc_act_nxt = 1'b0;
      end
    end else if (nc == 4'd0) begin
      emit = 1'b1;
    end else if (nc != 4'd1) begin
      // lead byte
      utf_exp_nxt = nc;
      utf_cnt_nxt = 4'd1;
      rune_nxt    = {{(tuacd_pkg::RUNE_W-7){1'b0}}, tuacd_pkg::lead_bits(c, nc)};
    end else begin
      // continuation byte
      rune_nxt    = {rune_r[tuacd_pkg::RUNE_W-7:0], c[5:0]};
      utf_cnt_nxt = utf_cnt_inc;
      if (utf_cnt_inc == utf_exp_r) begin
        emit = 1'b1;
        code = tuacd_pkg::rune_to_code(rune_nxt);
      end
    end
  end

  // state update on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= tuacd_pkg::PH_DATA;
      esc_act_r <= 1'b0;
      esc_len_r <= 4'd0;
      may_red_r <= 1'b0;
      may_def_r <= 1'b0;
      red_r     <= 1'b0;
      utf_exp_r <= 4'd0;
      utf_cnt_r <= 4'd0;
      rune_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      esc_act_r <= esc_act_nxt;
      esc_len_r <= esc_len_nxt;
      may_red_r <= may_red_nxt;
      may_def_r <= may_def_nxt;
      red_r     <= red_nxt;
      utf_exp_r <= utf_exp_nxt;
      utf_cnt_r <= utf_cnt_nxt;
      rune_r    <= rune_nxt;
    end
  end

  assign res.emit      = emit;
  assign res.char_code = code;
  assign res.red_ink   = red_r;

endmodule

>>> rtl/core/tuacd_out_stage.sv
// ---------------------------------------------------------------------------
// tuacd_out_stage
// Result register toward the receiver; sets when the pipeline may advance.
// ---------------------------------------------------------------------------
module tuacd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tuacd_pkg::tuacd_res_t res,
  input  logic                 fire,
  output logic                 adv,
  tuacd_out_if.source          out_chan
);

  logic       vld_r;
  logic [6:0] code_r;
  logic       red_r;

  // register free when empty or being taken
  assign adv = !vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= res.char_code;
      red_r  <= res.red_ink;
    end
  end

  assign out_chan.valid     = vld_r;
  assign out_chan.char_code = code_r;
  assign out_chan.red_ink   = red_r;

endmodule

>>> rtl/core/telnet_utf8_ansi_char_decoder_top.sv
// ---------------------------------------------------------------------------
// telnet_utf8_ansi_char_decoder_top
// Telnet byte stream to typewriter characters with red-ink flag.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan  : one received telnet byte per request (rx_byte).
//   out_chan : zero or one character per byte (char_code, red_ink).
//   Telnet commands, CR and escape sequences produce no result; UTF-8
//   runes produce one result on their last byte.
// Path: an accepted byte moves on to the result register once that is free
//   (two register stages: input register, result register).
// Throughput: one byte per cycle while out_chan.ready stays high; the decode
//   state is updated in a single pass.
// Reset: rst_n low at a clock edge clears both stages and the decode state
//   (data phase, no escape, black ink, no rune pending).
// Stall: while a result waits for out_chan.ready, the input register still
//   takes one more byte; in_chan.ready falls only when both stages are full.
// ---------------------------------------------------------------------------
`include "telnet_utf8_ansi_char_decoder_top_defines.svh"

module telnet_utf8_ansi_char_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  tuacd_in_if.sink    in_chan,
  tuacd_out_if.source out_chan
);

  tuacd_pkg::tuacd_item_t item;
  tuacd_pkg::tuacd_res_t  res;
  logic                   adv;
  logic                   fire;

  // byte in the input register is consumed
  assign fire = item.vld && adv;

  tuacd_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .adv     (adv),
    .item    (item)
  );

  tuacd_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .fire  (fire),
    .res   (res)
  );

  tuacd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .fire     (fire),
    .adv      (adv),
    .out_chan (out_chan)
  );

  // both stages full and receiver stalled: no new byte taken
  `TUACD_ASSERT_IMPL(a_full_blocks_in, item.vld && out_chan.valid && !out_chan.ready, !in_chan.ready)
  // accepted byte lands in the input register
  `TUACD_ASSERT_NEXT(a_accept_loads, in_chan.valid && in_chan.ready, item.vld)
  // a consumed byte that emits gives a valid result
  `TUACD_ASSERT_NEXT(a_emit_shows, fire && res.emit, out_chan.valid)

endmodule

>>> tb/telnet_utf8_ansi_char_decoder_top_tb.sv
// ---------------------------------------------------------------------------
// telnet_utf8_ansi_char_decoder_top_tb
// Self-checking bench for the telnet character decoder. A directed table
// covers telnet commands, CR, ink escapes and UTF-8 corner cases. Random
// traffic follows: runes, escapes, commands, stray bytes and noise, under
// several sender/receiver idle patterns. Every request is run through a
// local decoder model, and each character that comes out is compared with
// the oldest predicted character.
// ---------------------------------------------------------------------------
module telnet_utf8_ansi_char_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TN_NOP = 8'd241;
  localparam logic [7:0] CH_LOWEST_CONT = 8'h80;
  localparam logic [7:0] CH_HIGHEST_CONT = 8'hBF;

  // ink escapes, byte by byte
  localparam logic [7:0] RED_SEQ [5] = '{tuacd_pkg::CH_ESC, 8'h5B, 8'h33, 8'h31, 8'h6D};
  localparam logic [7:0] DFLT_SEQ [8] = '{tuacd_pkg::CH_ESC, 8'h5B, 8'h33, 8'h39, 8'h3B,
                                          8'h34, 8'h39, 8'h6D};

  // runes with their own typewriter codes, starting at 020
  localparam logic [tuacd_pkg::RUNE_W-1:0] SYM_RUNE [8] = '{
    42'h00B7, 42'h203E, 42'h2192, 42'h2283, 42'h2228, 42'h2227, 42'h2191, 42'h00D7
  };

  typedef struct packed {
    logic [6:0] char_code;
    logic       red_ink;
  } glyph_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_GLYPH} row_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    row_kind_t  kind;
    glyph_t     want;
  } row_t;

  // directed requests; typed results only where they are obvious
  localparam int DIR_ROWS_N = 25;
  localparam row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{8'h00, ROW_GLYPH,   '{7'h00, 1'b0}},  // null byte
    '{8'h7F, ROW_GLYPH,   '{7'h7F, 1'b0}},  // top of ASCII
    '{8'h0D, ROW_SILENT,  '{7'h00, 1'b0}},  // carriage return
    '{8'hFF, ROW_SILENT,  '{7'h00, 1'b0}},  // IAC
    '{8'hF1, ROW_SILENT,  '{7'h00, 1'b0}},  // NOP
    '{8'hFF, ROW_SILENT,  '{7'h00, 1'b0}},  // IAC
    '{8'hFB, ROW_SILENT,  '{7'h00, 1'b0}},  // WILL
    '{8'hFF, ROW_SILENT,  '{7'h00, 1'b0}},  // option byte, skipped
    '{8'hFF, ROW_SILENT,  '{7'h00, 1'b0}},  // IAC
    '{8'hFF, ROW_SILENT,  '{7'h00, 1'b0}},  // IAC IAC: 255 opens an 8-byte rune
    '{8'h1B, ROW_SILENT,  '{7'h00, 1'b0}},  // ESC [ CR 3 1 m
    '{8'h5B, ROW_SILENT,  '{7'h00, 1'b0}},
    '{8'h0D, ROW_SILENT,  '{7'h00, 1'b0}},  // CR inside escape
    '{8'h33, ROW_SILENT,  '{7'h00, 1'b0}},
    '{8'h31, ROW_SILENT,  '{7'h00, 1'b0}},
    '{8'h6D, ROW_SILENT,  '{7'h00, 1'b0}},  // red on
    '{8'hC2, ROW_SILENT,  '{7'h00, 1'b0}},  // two-byte lead
    '{8'h41, ROW_GLYPH,   '{7'h41, 1'b1}},  // ASCII inside a rune
    '{8'hB7, ROW_PREDICT, '{7'h00, 1'b0}},  // middle dot
    '{8'hBF, ROW_SILENT,  '{7'h00, 1'b0}},  // stray continuation
    '{8'hC1, ROW_SILENT,  '{7'h00, 1'b0}},  // overlong lead
    '{8'h81, ROW_PREDICT, '{7'h00, 1'b0}},  // overlong rune A
    '{8'h1B, ROW_SILENT,  '{7'h00, 1'b0}},  // unknown escape
    '{8'h58, ROW_SILENT,  '{7'h00, 1'b0}},
    '{8'h41, ROW_SILENT,  '{7'h00, 1'b0}}   // swallowed
  };

  logic clk;
  logic rst_n;

  tuacd_in_if  in_chan ();
  tuacd_out_if out_chan ();

  telnet_utf8_ansi_char_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  glyph_t glyph_q [$];
  int     err_cnt = 0;
  int     sent_cnt = 0;
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;

  // decoder model state, at reset values
  tuacd_pkg::tuacd_phase_t           link_ph = tuacd_pkg::PH_DATA;
  logic                              esc_on = 1'b0;
  logic [3:0]                        esc_len = 4'd0;
  logic                              maybe_red = 1'b0;
  logic                              maybe_dflt = 1'b0;
  logic                              red_on = 1'b0;
  logic [3:0]                        rune_len = 4'd0;
  logic [3:0]                        rune_seen = 4'd0;
  logic [tuacd_pkg::RUNE_W-1:0]      rune_acc = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("telnet_utf8_ansi_char_decoder_top_tb: errors");
    $finish;
  end

  function automatic logic [6:0] glyph_of(input logic [tuacd_pkg::RUNE_W-1:0] r);
    for (int i = 0; i < 8; i++) begin
      if (r == SYM_RUNE[i]) return 7'o020 + 7'(i);
    end
    if (r >= tuacd_pkg::RUNE_W'(128)) return tuacd_pkg::CH_SPACE;
    return r[6:0];
  endfunction

  // display filter: escapes, CR and rune assembly
  task automatic filter_byte(input logic [7:0] b, output bit emit, output logic [6:0] code);
    logic [3:0] pos;
    int         ones;
    emit = 1'b0;
    code = 7'd0;
    if (b == tuacd_pkg::CH_CR) return;
    if (b == tuacd_pkg::CH_ESC) begin
      esc_on = 1'b1;
      esc_len = 4'd1;
      maybe_red = 1'b1;
      maybe_dflt = 1'b1;
      return;
    end
    if (esc_on) begin
      pos = esc_len;
      if (!(maybe_red && pos < tuacd_pkg::RED_LEN && RED_SEQ[pos] == b))
        maybe_red = 1'b0;
      if (!(maybe_dflt && pos < tuacd_pkg::DEF_LEN && DFLT_SEQ[pos] == b))
        maybe_dflt = 1'b0;
      if (esc_len < tuacd_pkg::CNT_MAX) esc_len = esc_len + 4'd1;
      if (maybe_red && esc_len == tuacd_pkg::RED_LEN) begin
        red_on = 1'b1;
        esc_on = 1'b0;
      end else if (maybe_dflt && esc_len == tuacd_pkg::DEF_LEN) begin
        red_on = 1'b0;
        esc_on = 1'b0;
      end
      return;
    end
    ones = 0;
    for (int i = 7; i >= 0 && b[i]; i--) ones++;
    if (ones == 0) begin
      emit = 1'b1;
      code = b[6:0];
      return;
    end
    if (ones > 1) begin
      rune_len = 4'(ones);
      rune_seen = 4'd1;
      rune_acc = tuacd_pkg::RUNE_W'(b[6:0] & (7'h7F >> ones));
      return;
    end
    // continuation byte
    rune_acc = {rune_acc[tuacd_pkg::RUNE_W-7:0], b[5:0]};
    if (rune_seen < tuacd_pkg::CNT_MAX) rune_seen = rune_seen + 4'd1;
    if (rune_seen == rune_len) begin
      emit = 1'b1;
      code = glyph_of(rune_acc);
    end
  endtask

  // telnet layer on top of the display filter
  task automatic decode_byte(input logic [7:0] b, output bit emit, output glyph_t g);
    logic [6:0] code;
    emit = 1'b0;
    code = 7'd0;
    case (link_ph)
      tuacd_pkg::PH_CMD: begin
        link_ph = tuacd_pkg::PH_DATA;
        if (b >= tuacd_pkg::TN_WILL && b <= tuacd_pkg::TN_DONT) link_ph = tuacd_pkg::PH_OPT;
        else if (b == tuacd_pkg::TN_IAC) filter_byte(b, emit, code);
      end
      tuacd_pkg::PH_OPT: begin
        link_ph = tuacd_pkg::PH_DATA;
      end
      default: begin
        link_ph = tuacd_pkg::PH_DATA;
        if (b == tuacd_pkg::TN_IAC) link_ph = tuacd_pkg::PH_CMD;
        else filter_byte(b, emit, code);
      end
    endcase
    g.char_code = code;
    g.red_ink = red_on;
  endtask

  // one request on the input channel; returns at the accepting edge
  task automatic offer_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    bit     emit;
    glyph_t g;
    offer_byte(b);
    decode_byte(b, emit, g);
    if (emit) glyph_q.push_back(g);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (glyph_q.size() != 0);
  endtask

  // UTF-8 rune, possibly overlong, truncated or with ASCII in the middle
  task automatic gen_rune();
    int                           n, bits, split, cut, sel, k;
    logic [tuacd_pkg::RUNE_W-1:0] r;
    logic [7:0]                   lead;
    if ($urandom_range(99) < 35) begin
      k = $urandom_range(7);
      r = SYM_RUNE[k];
      n = (r < tuacd_pkg::RUNE_W'('h800)) ? 2 : 3;
    end else begin
      sel = $urandom_range(99);
      n = (sel < 45) ? 2 : (sel < 80) ? 3 : (sel < 90) ? 4 : $urandom_range(5, 8);
      bits = (n == 8) ? tuacd_pkg::RUNE_W : (7 - n) + 6 * (n - 1);
      r = tuacd_pkg::RUNE_W'({$urandom, $urandom});
      if ($urandom_range(3) == 0) r = tuacd_pkg::RUNE_W'($urandom_range(255));
      r = r & ~(~tuacd_pkg::RUNE_W'(0) << bits);
    end
    lead = (8'hFF << (8 - n)) | 8'(r >> (6 * (n - 1)));
    split = ($urandom_range(99) < 15) ? $urandom_range(1, n - 1) : 0;
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, n - 1) : n;
    if (n == 8) feed_byte(tuacd_pkg::TN_IAC);
    feed_byte(lead);
    for (int i = 1; i < cut; i++) begin
      if (i == split) feed_byte(8'($urandom_range(8'h20, 8'h7E)));
      feed_byte({2'b10, 6'(r >> (6 * (n - 1 - i)))});
    end
  endtask

  // ink escape; sometimes a broken prefix with junk first
  task automatic gen_escape();
    int         n;
    logic [7:0] b;
    bit         red;
    if ($urandom_range(99) < 25) begin
      red = $urandom_range(1);
      n = $urandom_range(1, red ? tuacd_pkg::RED_LEN - 1 : tuacd_pkg::DEF_LEN - 1);
      for (int i = 0; i < n; i++) feed_byte(red ? RED_SEQ[i] : DFLT_SEQ[i]);
      n = $urandom_range(1, 18);
      repeat (n) begin
        b = 8'($urandom_range(255));
        if (b == tuacd_pkg::CH_ESC) b = 8'h41;
        feed_byte(b);
      end
    end
    red = $urandom_range(1);
    n = red ? tuacd_pkg::RED_LEN : tuacd_pkg::DEF_LEN;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < 8) feed_byte(tuacd_pkg::CH_CR);
      feed_byte(red ? RED_SEQ[i] : DFLT_SEQ[i]);
    end
  endtask

  task automatic gen_telnet();
    int         sel;
    logic [7:0] cmd;
    sel = $urandom_range(99);
    if (sel < 25) cmd = TN_NOP;
    else if (sel < 70) cmd = 8'($urandom_range(tuacd_pkg::TN_WILL, tuacd_pkg::TN_DONT));
    else if (sel < 85) cmd = tuacd_pkg::TN_IAC;
    else cmd = 8'($urandom_range(254));
    feed_byte(tuacd_pkg::TN_IAC);
    feed_byte(cmd);
    if (cmd >= tuacd_pkg::TN_WILL && cmd <= tuacd_pkg::TN_DONT)
      feed_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int n_bytes);
    int         stop_at, sel, n;
    logic [7:0] b;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    stop_at = sent_cnt + n_bytes;
    while (sent_cnt < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom_range(127));
          if (b == tuacd_pkg::CH_ESC) b = 8'h20;
          feed_byte(b);
        end
      end else if (sel < 60) begin
        gen_rune();
      end else if (sel < 70) begin
        gen_telnet();
      end else if (sel < 85) begin
        gen_escape();
      end else if (sel < 90) begin
        // stray continuation run, sometimes long enough to saturate the count
        n = $urandom_range(1, 20);
        repeat (n) feed_byte(8'($urandom_range(CH_LOWEST_CONT, CH_HIGHEST_CONT)));
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) feed_byte(8'($urandom_range(255)));
      end
    end
    // hold off until every predicted character has come out
    drain_results();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    glyph_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (glyph_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected char_code %0o red_ink %0b", $time,
                 out_chan.char_code, out_chan.red_ink);
      end else begin
        want = glyph_q.pop_front();
        if (out_chan.char_code !== want.char_code) begin
          err_cnt++;
          $display("%0t: char_code expected %0o actual %0o", $time,
                   want.char_code, out_chan.char_code);
        end
        if (out_chan.red_ink !== want.red_ink) begin
          err_cnt++;
          $display("%0t: red_ink expected %0b actual %0b", $time,
                   want.red_ink, out_chan.red_ink);
        end
      end
    end
    out_chan.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // main sequence
  initial begin
    bit     emit;
    glyph_t g;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.rx_byte = 8'd0;
    out_chan.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      offer_byte(DIR_ROWS[i].rx_byte);
      decode_byte(DIR_ROWS[i].rx_byte, emit, g);
      case (DIR_ROWS[i].kind)
        ROW_GLYPH: glyph_q.push_back(DIR_ROWS[i].want);
        ROW_PREDICT: if (emit) glyph_q.push_back(g);
        default: ;
      endcase
    end
    drain_results();

    // random traffic under the idle patterns
    run_random(0, 0, 450);
    run_random(83, 0, 450);
    run_random(0, 83, 450);
    run_random(13, 13, 450);

    snk_stall_pct = 0;
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("telnet_utf8_ansi_char_decoder_top_tb: clean");
    end else begin
      $display("telnet_utf8_ansi_char_decoder_top_tb: errors");
    end
    $finish;
  end

endmodule
